// ===== rtl/nearest_edge_distance_assert.svh =====
// ----------------------------------------------------------------------------
// nearest_edge_distance assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_EDGE_DISTANCE_ASSERT_SVH
`define NEAREST_EDGE_DISTANCE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define NED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nearest_edge_distance: check failed");
// next-cycle implication
`define NED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nearest_edge_distance: check failed");
`else
`define NED_ASSERT_IMP(lbl, ante, cons)
`define NED_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/ned_pkg.sv =====
// ----------------------------------------------------------------------------
// ned_pkg
// Shared types and constants for the nearest edge distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package ned_pkg;

  // default sizing
  localparam int unsigned MAX_EDGES_DEF  = 4096;
  localparam int unsigned COORD_BITS_DEF = 8;

  // result format: unsigned Q9.8
  localparam int unsigned DIST_W   = 17;
  localparam int unsigned FRAC_W   = 8;
  localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

  // request opcodes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SQRT,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/nearest_edge_distance.sv =====
// ----------------------------------------------------------------------------
// nearest_edge_distance
// Brute-force nearest edge distance over a table of edge voxel coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: clear, load or
//   query. Clear and load finish in the cycle they are accepted. A query
//   scans the edge table, one entry per cycle from a RAM with one write
//   port and one registered read port, then runs a restoring square root,
//   one result bit per cycle. A query on an empty table or on an edge
//   voxel skips the scan and root. in_stall stays high while a query is
//   in flight.
//   Result channel (out_valid / out_stall) is a single output register; a
//   new request is accepted while a result waits there. A finished query
//   holds in its last state until that register is free.
//   Reset (synchronous, rst_n low) empties the table, zeroes the running
//   maximum and drops out_valid. Table contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_edge_distance #(
  parameter int unsigned MAX_EDGES  = ned_pkg::MAX_EDGES_DEF,
  parameter int unsigned COORD_BITS = ned_pkg::COORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_opcode,
  input  wire logic [COORD_BITS-1:0]      in_grid_x,
  input  wire logic [COORD_BITS-1:0]      in_grid_y,
  input  wire logic [COORD_BITS-1:0]      in_grid_z,
  input  wire logic                       in_is_edge,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [ned_pkg::DIST_W-1:0]      out_distance,
  output logic [ned_pkg::DIST_W-1:0]      out_max_distance,
  output logic                            out_valid_res
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned EW  = 3 * CB;
  localparam int unsigned D2W = 2 * CB + 2;
  localparam int unsigned SQW = D2W + 2 * ned_pkg::FRAC_W;
  localparam int unsigned DW  = ned_pkg::DIST_W;

  // edge table
  logic [EW-1:0] edge_mem [MAX_EDGES];
  logic [EW-1:0] rdata_r;
  logic          wr_en;

  // control state
  ned_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   edge_cnt_r, edge_cnt_nxt;
  logic [DW-1:0]   max_r, max_nxt;
  logic [CW-1:0]   scan_idx_r, scan_idx_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic            d2_vld_r, d2_vld_nxt;
  logic            out_valid_r, out_valid_nxt;

  // datapath state
  logic [CB-1:0]   qx_r, qx_nxt, qy_r, qy_nxt, qz_r, qz_nxt;
  logic [D2W-1:0]  d2_r, d2_nxt;
  logic [D2W-1:0]  best_r, best_nxt;
  logic [SQW-1:0]  rem_r, rem_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [DW-1:0]   res_dist_r, res_dist_nxt;
  logic            res_vld_r, res_vld_nxt;
  logic [DW-1:0]   out_distance_r, out_distance_nxt;
  logic [DW-1:0]   out_max_r, out_max_nxt;
  logic            out_vres_r, out_vres_nxt;

  // squared distance of the fetched entry
  logic [CB-1:0]   ex, ey, ez, dx, dy, dz;
  logic [2*CB-1:0] sqx, sqy, sqz;
  logic [SQW-1:0]  trial;
  logic [DW-1:0]   root_sat;
  logic [DW-1:0]   max_upd;

  assign ex = rdata_r[CB-1:0];
  assign ey = rdata_r[2*CB-1:CB];
  assign ez = rdata_r[3*CB-1:2*CB];
  assign dx = (qx_r > ex) ? (qx_r - ex) : (ex - qx_r);
  assign dy = (qy_r > ey) ? (qy_r - ey) : (ey - qy_r);
  assign dz = (qz_r > ez) ? (qz_r - ez) : (ez - qz_r);
  assign sqx = (2*CB)'(dx) * (2*CB)'(dx);
  assign sqy = (2*CB)'(dy) * (2*CB)'(dy);
  assign sqz = (2*CB)'(dz) * (2*CB)'(dz);

  // square root step and saturation to Q9.8
  assign trial    = root_r + bit_r;
  assign root_sat = (root_r > SQW'(ned_pkg::DIST_MAX)) ? ned_pkg::DIST_MAX
                                                        : root_r[DW-1:0];
  assign max_upd  = (res_dist_r > max_r) ? res_dist_r : max_r;

  // sequencer and next-state logic
  always_comb begin
    state_nxt        = state_r;
    edge_cnt_nxt     = edge_cnt_r;
    max_nxt          = max_r;
    scan_idx_nxt     = scan_idx_r;
    rd_vld_nxt       = 1'b0;
    d2_vld_nxt       = rd_vld_r;
    d2_nxt           = D2W'(sqx) + D2W'(sqy) + D2W'(sqz);
    qx_nxt           = qx_r;
    qy_nxt           = qy_r;
    qz_nxt           = qz_r;
    best_nxt         = best_r;
    rem_nxt          = rem_r;
    root_nxt         = root_r;
    bit_nxt          = bit_r;
    res_dist_nxt     = res_dist_r;
    res_vld_nxt      = res_vld_r;
    out_distance_nxt = out_distance_r;
    out_max_nxt      = out_max_r;
    out_vres_nxt     = out_vres_r;
    out_valid_nxt    = out_valid_r;
    wr_en            = 1'b0;
    in_stall         = (state_r != ned_pkg::ST_IDLE);

    // result taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // running minimum over the scan
    if (d2_vld_r && (d2_r < best_r)) begin
      best_nxt = d2_r;
    end

    unique case (state_r)
      ned_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (ned_pkg::opcode_t'(in_opcode))
            ned_pkg::OP_CLEAR: begin
              edge_cnt_nxt = '0;
              max_nxt      = '0;
            end
            ned_pkg::OP_LOAD: begin
              if (edge_cnt_r < CW'(MAX_EDGES)) begin
                wr_en        = 1'b1;
                edge_cnt_nxt = edge_cnt_r + CW'(1);
              end
            end
            ned_pkg::OP_QUERY: begin
              qx_nxt       = in_grid_x;
              qy_nxt       = in_grid_y;
              qz_nxt       = in_grid_z;
              best_nxt     = '1;
              scan_idx_nxt = '0;
              res_dist_nxt = '0;
              if (edge_cnt_r == '0) begin
                res_vld_nxt = 1'b0;
                state_nxt   = ned_pkg::ST_FINISH;
              end else if (in_is_edge) begin
                res_vld_nxt = 1'b1;
                state_nxt   = ned_pkg::ST_FINISH;
              end else begin
                state_nxt   = ned_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      // one table read per cycle
      ned_pkg::ST_SCAN: begin
        rd_vld_nxt   = 1'b1;
        scan_idx_nxt = scan_idx_r + CW'(1);
        if (scan_idx_r == edge_cnt_r - CW'(1)) begin
          state_nxt = ned_pkg::ST_DRAIN;
        end
      end
      // wait for the last compare, then seed the root
      ned_pkg::ST_DRAIN: begin
        if (!rd_vld_r && !d2_vld_r) begin
          rem_nxt   = {best_r, (2*ned_pkg::FRAC_W)'(0)};
          root_nxt  = '0;
          bit_nxt   = SQW'(1) << (SQW - 2);
          state_nxt = ned_pkg::ST_SQRT;
        end
      end
      // restoring square root, one result bit per cycle
      ned_pkg::ST_SQRT: begin
        if (bit_r == '0) begin
          res_dist_nxt = root_sat;
          res_vld_nxt  = 1'b1;
          state_nxt    = ned_pkg::ST_FINISH;
        end else begin
          if (rem_r >= trial) begin
            rem_nxt  = rem_r - trial;
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      // hand the result to the output register
      ned_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = res_dist_r;
          out_max_nxt      = max_upd;
          out_vres_nxt     = res_vld_r;
          max_nxt          = max_upd;
          state_nxt        = ned_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ned_pkg::ST_IDLE;
    endcase
  end

  // table RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      edge_mem[edge_cnt_r[AW-1:0]] <= {in_grid_z, in_grid_y, in_grid_x};
    end
    rdata_r <= edge_mem[scan_idx_r[AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ned_pkg::ST_IDLE;
      edge_cnt_r  <= '0;
      max_r       <= '0;
      rd_vld_r    <= 1'b0;
      d2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      max_r       <= max_nxt;
      rd_vld_r    <= rd_vld_nxt;
      d2_vld_r    <= d2_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    scan_idx_r     <= scan_idx_nxt;
    qx_r           <= qx_nxt;
    qy_r           <= qy_nxt;
    qz_r           <= qz_nxt;
    d2_r           <= d2_nxt;
    best_r         <= best_nxt;
    rem_r          <= rem_nxt;
    root_r         <= root_nxt;
    bit_r          <= bit_nxt;
    res_dist_r     <= res_dist_nxt;
    res_vld_r      <= res_vld_nxt;
    out_distance_r <= out_distance_nxt;
    out_max_r      <= out_max_nxt;
    out_vres_r     <= out_vres_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_distance     = out_distance_r;
  assign out_max_distance = out_max_r;
  assign out_valid_res    = out_vres_r;

  // checks
  `include "nearest_edge_distance_assert.svh"

  `NED_ASSERT_IMP(a_cnt_bound, 1'b1, edge_cnt_r <= CW'(MAX_EDGES))
  `NED_ASSERT_IMP(a_scan_in_range, state_r == ned_pkg::ST_SCAN, scan_idx_r < edge_cnt_r)
  `NED_ASSERT_IMP(a_empty_zero, out_valid_r && !out_vres_r, out_distance_r == '0)
  `NED_ASSERT_IMP(a_max_covers, out_valid_r, out_max_r >= out_distance_r)
  `NED_ASSERT_NXT(a_drain_quiet, state_r == ned_pkg::ST_SQRT, !rd_vld_r && !d2_vld_r)

endmodule

`default_nettype wire
